/* rtl/core/sseq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sseq_pkg
// Shared types, constants and helpers of the step sequencer grid.
// ----------------------------------------------------------------------------
package sseq_pkg;

	localparam int SSEQ_ROWS    = 4;
	localparam int SSEQ_COLUMNS = 8;
	localparam int SSEQ_CELL_W  = 2;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_BASE_NOTE    = 3'd0;
	localparam logic [2:0] REG_NOTE_VEL     = 3'd1;
	localparam logic [2:0] REG_ROW_INTERVAL = 3'd2;
	localparam logic [2:0] REG_COLOUR_ONE   = 3'd3;
	localparam logic [2:0] REG_COLOUR_TWO   = 3'd4;
	localparam logic [2:0] REG_COLOUR_THREE = 3'd5;

	localparam logic [6:0]  RST_BASE_NOTE    = 7'd32;
	localparam logic [6:0]  RST_NOTE_VEL     = 7'd100;
	localparam logic [1:0]  RST_ROW_INTERVAL = 2'd3;
	localparam logic [23:0] RST_COLOUR_ONE   = 24'hFF0000;
	localparam logic [23:0] RST_COLOUR_TWO   = 24'h00FF00;
	localparam logic [23:0] RST_COLOUR_THREE = 24'h0000FF;

	// event_type codes
	localparam logic [1:0] EVT_PIXEL = 2'd0;
	localparam logic [1:0] EVT_NOTE  = 2'd1;
	localparam logic [1:0] EVT_CC    = 2'd2;
	localparam logic [1:0] EVT_FLUSH = 2'd3;

	localparam logic [23:0] WHITE         = 24'hFFFFFF;
	localparam logic [6:0]  ALL_NOTES_OFF = 7'd123;
	localparam logic [6:0]  NOTE_MAX      = 7'd127;

	typedef struct packed {
		logic [6:0]  base_note;
		logic [6:0]  note_velocity;
		logic [1:0]  row_interval;
		logic [23:0] colour_one;
		logic [23:0] colour_two;
		logic [23:0] colour_three;
	} cfg_t;

	typedef enum logic [1:0] {
		RD_KEY,
		RD_PREV,
		RD_CUR,
		RD_PREV_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		EV_KEY_PIXEL,
		EV_CC,
		EV_PREV_PIXEL,
		EV_CUR_PIXEL,
		EV_NOTE,
		EV_FLUSH
	} emit_t;

	typedef struct packed {
		logic    load_key;
		logic    step_adv;
		logic    row_clr;
		logic    row_inc;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    emit;
		emit_t   ev;
	} cmd_t;

	typedef struct packed {
		logic key_ok;
		logic cell_nz;
		logic last_row;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_WR,
		ST_TICK_CC,
		ST_ROW_PREV,
		ST_ROW_CUR,
		ST_ROW_NOTE,
		ST_FLUSH
	} state_t;

	function automatic logic [23:0] cell_colour(input cfg_t c, input logic [1:0] v);
		logic [23:0] col;
		case (v)
			2'd1:    col = c.colour_one;
			2'd2:    col = c.colour_two;
			2'd3:    col = c.colour_three;
			default: col = '0;
		endcase
		return col;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/sseq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sseq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sseq_ram
	import sseq_pkg::*;
#(
	parameter int WIDTH = SSEQ_CELL_W,
	parameter int DEPTH = SSEQ_ROWS * SSEQ_COLUMNS
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/sseq_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sseq_regs
// APB-style configuration registers: note base, velocity, row interval and
// the three cell colours.
// ----------------------------------------------------------------------------
module sseq_regs
	import sseq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign idx   = paddr[4:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_note     <= RST_BASE_NOTE;
			cfg_q.note_velocity <= RST_NOTE_VEL;
			cfg_q.row_interval  <= RST_ROW_INTERVAL;
			cfg_q.colour_one    <= RST_COLOUR_ONE;
			cfg_q.colour_two    <= RST_COLOUR_TWO;
			cfg_q.colour_three  <= RST_COLOUR_THREE;
		end else if (wr_en) begin
			unique case (idx)
				REG_BASE_NOTE:    cfg_q.base_note     <= pwdata[6:0];
				REG_NOTE_VEL:     cfg_q.note_velocity <= pwdata[6:0];
				REG_ROW_INTERVAL: cfg_q.row_interval  <= pwdata[1:0];
				REG_COLOUR_ONE:   cfg_q.colour_one    <= pwdata[23:0];
				REG_COLOUR_TWO:   cfg_q.colour_two    <= pwdata[23:0];
				REG_COLOUR_THREE: cfg_q.colour_three  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BASE_NOTE:    prdata = APB_DW'(cfg_q.base_note);
			REG_NOTE_VEL:     prdata = APB_DW'(cfg_q.note_velocity);
			REG_ROW_INTERVAL: prdata = APB_DW'(cfg_q.row_interval);
			REG_COLOUR_ONE:   prdata = APB_DW'(cfg_q.colour_one);
			REG_COLOUR_TWO:   prdata = APB_DW'(cfg_q.colour_two);
			REG_COLOUR_THREE: prdata = APB_DW'(cfg_q.colour_three);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/core/sseq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sseq_ctrl
// Sequencer state machine: walks a key press or a tick through its reads,
// writes and result words, one word per cycle during a tick.
// ----------------------------------------------------------------------------
module sseq_ctrl
	import sseq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic kind,
	input  stat_t     stat,
	output logic      busy,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_KEY;
		cmd.ev     = EV_KEY_PIXEL;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_key = 1'b1;
					if (kind) begin
						cmd.step_adv = 1'b1;
						cmd.row_clr  = 1'b1;
						state_d      = ST_TICK_CC;
					end else if (stat.key_ok) begin
						state_d = ST_KEY_RD;
					end
				end
			end
			ST_KEY_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_KEY;
				state_d    = ST_KEY_WR;
			end
			ST_KEY_WR: begin
				cmd.wr_en = 1'b1;
				cmd.emit  = 1'b1;
				cmd.ev    = EV_KEY_PIXEL;
				state_d   = ST_IDLE;
			end
			ST_TICK_CC: begin
				cmd.emit   = 1'b1;
				cmd.ev     = EV_CC;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PREV;
				state_d    = ST_ROW_PREV;
			end
			ST_ROW_PREV: begin
				cmd.emit   = 1'b1;
				cmd.ev     = EV_PREV_PIXEL;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CUR;
				state_d    = ST_ROW_CUR;
			end
			ST_ROW_CUR: begin
				cmd.emit = 1'b1;
				cmd.ev   = EV_CUR_PIXEL;
				if (stat.cell_nz) begin
					state_d = ST_ROW_NOTE;
				end else if (stat.last_row) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_PREV_NEXT;
					cmd.row_inc = 1'b1;
					state_d     = ST_ROW_PREV;
				end
			end
			ST_ROW_NOTE: begin
				cmd.emit = 1'b1;
				cmd.ev   = EV_NOTE;
				if (stat.last_row) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_PREV_NEXT;
					cmd.row_inc = 1'b1;
					state_d     = ST_ROW_PREV;
				end
			end
			ST_FLUSH: begin
				cmd.emit = 1'b1;
				cmd.ev   = EV_FLUSH;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

/* rtl/core/sseq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sseq_datapath
// Pattern store with reset-valid bits, step and row counters, note math and
// the registered result word.
// ----------------------------------------------------------------------------
module sseq_datapath
	import sseq_pkg::*;
#(
	parameter int ROWS    = SSEQ_ROWS,
	parameter int COLUMNS = SSEQ_COLUMNS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cfg_t             cfg,
	input  cmd_t             cmd,
	input  wire logic [4:0]  key_index,
	output stat_t            stat,
	output logic             result_valid,
	output logic      [1:0]  event_type,
	output logic      [4:0]  pixel_index,
	output logic      [23:0] pixel_colour,
	output logic      [6:0]  note_number,
	output logic      [6:0]  note_value,
	output logic             last_of_run
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW    = $clog2(COLUMNS);

	logic [4:0]             key_q;
	logic [SW-1:0]          step_q;
	logic [RW-1:0]          row_q;
	logic [RW-1:0]          row_nx;
	logic [SW-1:0]          prev_col;
	logic [CELLS-1:0]       valid_q;
	logic                   rd_valid_s1;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          prev_addr;
	logic [AW-1:0]          cur_addr;
	logic [SSEQ_CELL_W-1:0] ram_rdata;
	logic [SSEQ_CELL_W-1:0] cell_val;
	logic [SSEQ_CELL_W-1:0] cell_nx;
	logic [4:0]             row_off;
	logic [7:0]             note_sum;
	logic [6:0]             note_sat;

	logic                   result_valid_q;
	logic [1:0]             ev_type_q;
	logic [4:0]             pix_q;
	logic [23:0]            col_q;
	logic [6:0]             num_q;
	logic [6:0]             val_q;
	logic                   last_q;
	logic [1:0]             ev_type_d;
	logic [4:0]             pix_d;
	logic [23:0]            col_d;
	logic [6:0]             num_d;
	logic [6:0]             val_d;
	logic                   last_d;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
		input logic [SW-1:0] c);
		return AW'(int'(r) * COLUMNS + int'(c));
	endfunction

	assign row_nx    = row_q + 1'b1;
	assign prev_col  = (step_q == '0) ? SW'(COLUMNS - 1) : step_q - 1'b1;
	assign prev_addr = cell_addr(row_q, prev_col);
	assign cur_addr  = cell_addr(row_q, step_q);
	assign wr_addr   = AW'(key_q);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_KEY:       rd_addr = AW'(key_q);
			RD_PREV:      rd_addr = prev_addr;
			RD_CUR:       rd_addr = cur_addr;
			RD_PREV_NEXT: rd_addr = cell_addr(row_nx, prev_col);
			default:      rd_addr = AW'(key_q);
		endcase
	end

	sseq_ram #(
		.WIDTH(SSEQ_CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(cell_nx),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// a cell never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign cell_val = rd_valid_s1 ? ram_rdata : '0;
	assign cell_nx  = cell_val + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			row_q  <= '0;
		end else begin
			if (cmd.step_adv) begin
				step_q <= (step_q == SW'(COLUMNS - 1)) ? '0 : step_q + 1'b1;
			end
			if (cmd.row_clr) begin
				row_q <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= key_index;
		end
	end

	assign stat.key_ok   = (int'(key_index) < CELLS);
	assign stat.cell_nz  = (cell_val != '0);
	assign stat.last_row = (row_q == RW'(ROWS - 1));

	// saturate the note at the top of the range
	assign row_off  = 5'(row_q) * 5'(cfg.row_interval);
	assign note_sum = 8'(cfg.base_note) + 8'(cell_val) + 8'(row_off);
	assign note_sat = note_sum[7] ? NOTE_MAX : note_sum[6:0];

	always_comb begin
		ev_type_d = EVT_PIXEL;
		pix_d     = '0;
		col_d     = '0;
		num_d     = '0;
		val_d     = '0;
		last_d    = 1'b0;
		case (cmd.ev)
			EV_KEY_PIXEL: begin
				pix_d  = key_q;
				col_d  = cell_colour(cfg, cell_nx);
				last_d = 1'b1;
			end
			EV_CC: begin
				ev_type_d = EVT_CC;
				num_d     = ALL_NOTES_OFF;
				val_d     = ALL_NOTES_OFF;
			end
			EV_PREV_PIXEL: begin
				pix_d = 5'(prev_addr);
				col_d = cell_colour(cfg, cell_val);
			end
			EV_CUR_PIXEL: begin
				pix_d = 5'(cur_addr);
				col_d = WHITE - cell_colour(cfg, cell_val);
			end
			EV_NOTE: begin
				ev_type_d = EVT_NOTE;
				num_d     = note_sat;
				val_d     = cfg.note_velocity;
			end
			EV_FLUSH: begin
				ev_type_d = EVT_FLUSH;
				last_d    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit;
			if (cmd.emit) begin
				last_q <= last_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ev_type_q <= ev_type_d;
			pix_q     <= pix_d;
			col_q     <= col_d;
			num_q     <= num_d;
			val_q     <= val_d;
		end
	end

	assign result_valid = result_valid_q;
	assign event_type   = ev_type_q;
	assign pixel_index  = pix_q;
	assign pixel_colour = col_q;
	assign note_number  = num_q;
	assign note_value   = val_q;
	assign last_of_run  = last_q;

endmodule
`default_nettype wire

/* rtl/core/step_sequencer_grid.sv */
// A key press (kind 0) is taken when start is high and busy is low; busy then
// stays high through ST_KEY_RD and ST_KEY_WR, and its single pixel word is
// registered from ST_KEY_WR. A key_index outside the grid is taken and
// dropped, with no word and no busy cycle. A tick (kind 1) keeps busy high
// through ST_TICK_CC, ST_ROW_PREV and ST_ROW_CUR per row (plus ST_ROW_NOTE
// on a set cell) and ST_FLUSH, and emits one word per cycle; the flush word
// (last_of_run) shows as busy falls. The pattern memory's single read port
// needs one read per row for the previous column and one for the current
// one. Words show on the result ports for exactly one cycle, marked by
// result_valid; the receiver cannot stall them. The pattern store reads as
// all zero right after reset, with no clearing pass. Write configuration
// registers only while busy is low and no word is still pending.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// step_sequencer_grid
// Grid step sequencer: key presses edit cells, ticks play one column.
// ----------------------------------------------------------------------------
module step_sequencer_grid
	import sseq_pkg::*;
#(
	parameter int ROWS    = SSEQ_ROWS,
	parameter int COLUMNS = SSEQ_COLUMNS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [4:0]        key_index,
	output logic                   result_valid,
	output logic      [1:0]        event_type,
	output logic      [4:0]        pixel_index,
	output logic      [23:0]       pixel_colour,
	output logic      [6:0]        note_number,
	output logic      [6:0]        note_value,
	output logic                   last_of_run
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	assign pready = 1'b1;

	sseq_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	sseq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	sseq_datapath #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.key_index   (key_index),
		.stat        (stat),
		.result_valid(result_valid),
		.event_type  (event_type),
		.pixel_index (pixel_index),
		.pixel_colour(pixel_colour),
		.note_number (note_number),
		.note_value  (note_value),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

/* rtl/core/sseq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sseq_checker
// Port-level timing checks of the step sequencer grid, bound to the top.
// ----------------------------------------------------------------------------
module sseq_checker
	import sseq_pkg::*;
#(
	parameter int ROWS    = SSEQ_ROWS,
	parameter int COLUMNS = SSEQ_COLUMNS
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              kind,
	input wire logic [4:0]        key_index,
	input wire logic              result_valid,
	input wire logic [1:0]        event_type,
	input wire logic [6:0]        note_number,
	input wire logic [6:0]        note_value,
	input wire logic              last_of_run
);

	logic accept;
	logic key_ok;

	assign accept = start && !busy;
	assign key_ok = (int'(key_index) < ROWS * COLUMNS);

	// every word comes out of a busy cycle
	a_word_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word without a preceding busy cycle");

	// the final word of a run leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |-> !busy)
		else $error("last word while still busy");

	// a key press on the grid keeps busy high, then gives one pixel word marked last
	a_key_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !kind && key_ok) |=> busy ##1 busy
			##1 (result_valid && last_of_run && event_type == EVT_PIXEL))
		else $error("key press word missing or late");

	// a key off the grid is dropped
	a_key_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !kind && !key_ok) |=> (!busy && !result_valid))
		else $error("off-grid key press not dropped");

	// a tick opens with the all-notes-off word
	a_tick_cc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind) |=> ##1 (result_valid && event_type == EVT_CC
			&& note_number == ALL_NOTES_OFF && note_value == ALL_NOTES_OFF))
		else $error("tick did not open with all-notes-off");

endmodule

bind step_sequencer_grid sseq_checker #(
	.ROWS   (ROWS),
	.COLUMNS(COLUMNS)
) u_sseq_checker (.*);
`default_nettype wire
